@@ design/free_list_region_allocator_unit_macros.svh @@
// Assertion macros for the free list region allocator
`ifndef FREE_LIST_REGION_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_REGION_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define FLRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define FLRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ design/flra_pkg.sv @@
// Types and constants shared by the free list region allocator
package flra_pkg;
   localparam int START_W = 25;
   localparam int LEN_W = 26;
   localparam int ENTRY_W = START_W + LEN_W;
   localparam logic [LEN_W-1:0] POOL_RESET = 26'd33554432;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic operation;
      logic [LEN_W-1:0] region_size;
      logic [START_W-1:0] region_offset;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [START_W-1:0] granted_offset;
      logic [LEN_W-1:0] granted_size;
   } rsp_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0] length;
   } entry_type;
endpackage

@@ design/flra_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module flra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/free_list_region_allocator_unit.sv @@
// Top level of the free list region allocator: sequencer around one entry RAM
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------
//  request | req_item, start, busy       | taken when start & !busy & !csr_wr_en
//  result  | rsp_item, rsp_valid         | one-cycle strobe, no back-pressure
//  config  | csr_wr_en, csr_wr_data      | csr_wr_en in S_IDLE or S_SEED
//
// An allocate reads one entry a cycle until an exact match or the last entry, decides,
// then removes an exact match by shifting the tail down, else carves the largest entry
// or reports no fit. A free scans up to the insert point, then merges with a neighbour,
// inserts by shifting the tail up, or reports the table full. The next item can be
// taken in the cycle after the result strobe. Reset and a pool write reseed entry 0
// and the count through S_SEED; stale entries past the count are never read. The
// receiver cannot stall the result.
`include "free_list_region_allocator_unit_macros.svh"
module free_list_region_allocator_unit import flra_pkg::*; #(
   parameter int FREE_ENTRIES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_item,
   output logic rsp_valid,
   output rsp_type rsp_item,
   input  logic csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);
   localparam int AW = $clog2(FREE_ENTRIES);
   localparam int CW = $clog2(FREE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SEED = 4'd1;
   localparam logic [3:0] S_ASCAN = 4'd2;
   localparam logic [3:0] S_ADEC = 4'd3;
   localparam logic [3:0] S_ASHIFT = 4'd4;
   localparam logic [3:0] S_FSCAN = 4'd5;
   localparam logic [3:0] S_FDEC = 4'd6;
   localparam logic [3:0] S_FSHIFT = 4'd7;
   localparam logic [3:0] S_RESP = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [LEN_W-1:0] pool_ff, pool_in;
   logic [CW-1:0] count_ff, count_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic [CW-1:0] idx_ff, idx_in;      // next read address
   logic [CW-1:0] pos_ff, pos_in;      // index of data arriving now
   logic rd_live_ff, rd_live_in;       // a read is in flight
   logic found_ff, found_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic [AW-1:0] big_ff, big_in;
   entry_type big_e_ff, big_e_in;
   entry_type prev_ff, prev_in;
   logic have_prev_ff, have_prev_in;
   entry_type cur_ff, cur_in;
   logic have_cur_ff, have_cur_in;
   entry_type carry_ff, carry_in;      // entry carried during an upward shift

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   flra_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [LEN_W:0] prev_end, free_end, sum_prev, sum_cur;
   assign prev_end = {1'b0, 1'b0, prev_ff.start} + {1'b0, prev_ff.length};
   assign free_end = {1'b0, 1'b0, req_ff.region_offset} + {1'b0, req_ff.region_size};
   assign sum_prev = {1'b0, prev_ff.length} + {1'b0, req_ff.region_size};
   assign sum_cur = {1'b0, cur_ff.length} + {1'b0, req_ff.region_size};

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_item = rsp_ff;

   always_comb begin
      state_in = state_ff;
      pool_in = pool_ff;
      count_in = count_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      rd_live_in = 1'b0;
      found_in = found_ff;
      hit_in = hit_ff;
      big_in = big_ff;
      big_e_in = big_e_ff;
      prev_in = prev_ff;
      have_prev_in = have_prev_ff;
      cur_in = cur_ff;
      have_cur_in = have_cur_ff;
      carry_in = carry_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               pool_in = csr_wr_data;
               state_in = S_SEED;
            end else if (start) begin
               req_in = req_item;
               rsp_in = '0;
               idx_in = '0;
               pos_in = '0;
               found_in = 1'b0;
               big_in = '0;
               big_e_in = '0;
               have_prev_in = 1'b0;
               have_cur_in = 1'b0;
               state_in = (req_item.operation == OP_ALLOC) ? S_ASCAN : S_FSCAN;
            end
         end
         S_SEED: begin
            // rewrite entry 0 and the count; a fresh write reseeds again
            wr_en = 1'b1;
            wr_data.start = '0;
            wr_data.length = pool_ff;
            count_in = CW'(1);
            state_in = S_IDLE;
            if (csr_wr_en) begin
               pool_in = csr_wr_data;
               state_in = S_SEED;
            end
         end
         S_ASCAN: begin
            // issue reads while idx below count, evaluate arriving data
            if (!found_ff && idx_ff < count_ff) begin
               idx_in = idx_ff + CW'(1);
               rd_live_in = 1'b1;
            end
            if (rd_live_ff && !found_ff) begin
               pos_in = pos_ff + CW'(1);
               if (rd_data.length == req_ff.region_size) begin
                  found_in = 1'b1;
                  hit_in = pos_ff[AW-1:0];
                  big_e_in = rd_data;
               end else if (pos_ff == '0 || rd_data.length > big_e_ff.length) begin
                  big_in = pos_ff[AW-1:0];
                  big_e_in = rd_data;
               end
            end
            if (found_ff || (!rd_live_ff && idx_ff >= count_ff)) begin
               state_in = S_ADEC;
            end
         end
         S_ADEC: begin
            if (found_ff) begin
               rsp_in.granted_offset = big_e_ff.start;
               rsp_in.granted_size = req_ff.region_size;
               idx_in = CW'(hit_ff) + CW'(1);
               pos_in = CW'(hit_ff);
               state_in = S_ASHIFT;
            end else if (count_ff != '0 && big_e_ff.length >= req_ff.region_size) begin
               rsp_in.granted_offset = big_e_ff.start;
               rsp_in.granted_size = req_ff.region_size;
               wr_en = 1'b1;
               wr_addr = big_ff;
               wr_data.start = big_e_ff.start + req_ff.region_size[START_W-1:0];
               wr_data.length = big_e_ff.length - req_ff.region_size;
               state_in = S_RESP;
            end else begin
               rsp_in.status = ST_NO_FIT;
               state_in = S_RESP;
            end
         end
         S_ASHIFT: begin
            // read idx, write previous slot when data arrives
            if (idx_ff < count_ff && !rd_live_ff) begin
               rd_live_in = 1'b1;
            end else if (rd_live_ff) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_data;
               pos_in = idx_ff;
               idx_in = idx_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end
         S_FSCAN: begin
            // walk until an entry with start not below offset
            if (rd_live_ff) begin
               if (rd_data.start < req_ff.region_offset) begin
                  prev_in = rd_data;
                  have_prev_in = 1'b1;
                  pos_in = pos_ff + CW'(1);
               end else begin
                  cur_in = rd_data;
                  have_cur_in = 1'b1;
                  state_in = S_FDEC;
               end
            end
            if (state_in == S_FSCAN) begin
               if (idx_ff < count_ff && (!rd_live_ff || rd_data.start < req_ff.region_offset)
                   && idx_ff == pos_in) begin
                  idx_in = idx_ff + CW'(1);
                  rd_live_in = 1'b1;
               end else if (!rd_live_ff && idx_ff >= count_ff) begin
                  state_in = S_FDEC;
               end else if (!rd_live_ff) begin
                  state_in = S_FDEC;
               end
            end
         end
         S_FDEC: begin
            if (have_prev_ff && prev_end == {2'b0, req_ff.region_offset}) begin
               wr_en = 1'b1;
               wr_addr = AW'(pos_ff - CW'(1));
               wr_data.start = prev_ff.start;
               wr_data.length = sum_prev[LEN_W] ? LEN_MAX : sum_prev[LEN_W-1:0];
               state_in = S_RESP;
            end else if (have_cur_ff && free_end == {2'b0, cur_ff.start}) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data.start = req_ff.region_offset;
               wr_data.length = sum_cur[LEN_W] ? LEN_MAX : sum_cur[LEN_W-1:0];
               state_in = S_RESP;
            end else if (count_ff < FULL_COUNT) begin
               // put new entry at pos, carry old tail upward
               carry_in = cur_ff;
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data.start = req_ff.region_offset;
               wr_data.length = req_ff.region_size;
               idx_in = pos_ff + CW'(1);
               state_in = have_cur_ff ? S_FSHIFT : S_RESP;
               count_in = count_ff + CW'(1);
            end else begin
               rsp_in.status = ST_FULL;
               state_in = S_RESP;
            end
         end
         S_FSHIFT: begin
            // idx is the slot to write with carry; read it first if live
            if (!rd_live_ff) begin
               rd_live_in = (idx_ff < count_ff - CW'(1));
               rd_addr = idx_ff[AW-1:0];
               if (idx_ff >= count_ff - CW'(1)) begin
                  wr_en = 1'b1;
                  wr_addr = idx_ff[AW-1:0];
                  wr_data = carry_ff;
                  state_in = S_RESP;
               end
            end else begin
               wr_en = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = carry_ff;
               carry_in = rd_data;
               idx_in = idx_ff + CW'(1);
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SEED;
         pool_ff <= POOL_RESET;
         count_ff <= CW'(1);
         rd_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         count_ff <= count_in;
         rd_live_ff <= rd_live_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      big_ff <= big_in;
      big_e_ff <= big_e_in;
      prev_ff <= prev_in;
      have_prev_ff <= have_prev_in;
      cur_ff <= cur_in;
      have_cur_ff <= have_cur_in;
      carry_ff <= carry_in;
   end

   `FLRA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= FULL_COUNT,
      "entry count exceeds table")
   `FLRA_ASSERT_NEXT(a_resp_one, clock, reset, rsp_valid, !rsp_valid,
      "result strobe longer than one cycle")
   `FLRA_ASSERT_IMP(a_resp_status, clock, reset, rsp_valid,
      rsp_item.status == ST_DONE || rsp_item.granted_size == '0,
      "failed item carries a grant")
endmodule

@@ test/tb_free_list_region_allocator_unit.sv @@
// Self-checking testbench for the free list region allocator unit
module tb_free_list_region_allocator_unit;
   import flra_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [LEN_W-1:0] POOL_MAX = {LEN_W{1'b1}};

   // Shadow of the free table plus the queue of results still owed by the block
   class region_scoreboard;
      logic [START_W-1:0] hole_start[TABLE_DEPTH];
      logic [LEN_W-1:0] hole_len[TABLE_DEPTH];
      int hole_count;
      rsp_type owed[$];
      int mismatches;

      function new();
         mismatches = 0;
         reseed(POOL_RESET);
      endfunction

      function void reseed(logic [LEN_W-1:0] pool);
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            hole_start[i] = '0;
            hole_len[i] = '0;
         end
         hole_len[0] = pool;
         hole_count = 1;
      endfunction

      function logic [LEN_W-1:0] clamp_len(logic [LEN_W:0] v);
         return v > {1'b0, LEN_MAX} ? LEN_MAX : v[LEN_W-1:0];
      endfunction

      // Predict the result of one accepted item, update the shadow and queue it
      function rsp_type note_item(req_type r);
         rsp_type res;
         int exact, big, pos;
         bit found;
         res = '0;
         res.status = ST_DONE;
         if (r.operation == OP_ALLOC) begin
            exact = hole_count;
            big = 0;
            found = 0;
            for (int i = 0; i < hole_count; i++) begin
               if (hole_len[i] == r.region_size) begin
                  exact = i;
                  found = 1;
                  break;
               end
               if (hole_len[i] > hole_len[big]) big = i;
            end
            if (found) begin
               res.granted_offset = hole_start[exact];
               res.granted_size = r.region_size;
               for (int i = exact; i + 1 < hole_count; i++) begin
                  hole_start[i] = hole_start[i + 1];
                  hole_len[i] = hole_len[i + 1];
               end
               hole_count--;
               hole_start[hole_count] = '0;
               hole_len[hole_count] = '0;
            end else if (hole_count > 0 && hole_len[big] >= r.region_size) begin
               res.granted_offset = hole_start[big];
               res.granted_size = r.region_size;
               hole_start[big] = hole_start[big] + r.region_size[START_W-1:0];
               hole_len[big] = hole_len[big] - r.region_size;
            end else begin
               res.status = ST_NO_FIT;
            end
         end else begin
            pos = 0;
            while (pos < hole_count && hole_start[pos] < r.region_offset) pos++;
            if (pos > 0 && ({1'b0, hole_start[pos - 1]} + hole_len[pos - 1])
                  == {{(LEN_W + 1 - START_W){1'b0}}, r.region_offset}) begin
               hole_len[pos - 1] = clamp_len({1'b0, hole_len[pos - 1]} + r.region_size);
            end else if (pos < hole_count && ({1'b0, r.region_offset} + r.region_size)
                  == {{(LEN_W + 1 - START_W){1'b0}}, hole_start[pos]}) begin
               hole_start[pos] = r.region_offset;
               hole_len[pos] = clamp_len({1'b0, hole_len[pos]} + r.region_size);
            end else if (hole_count < TABLE_DEPTH) begin
               for (int i = hole_count; i > pos; i--) begin
                  hole_start[i] = hole_start[i - 1];
                  hole_len[i] = hole_len[i - 1];
               end
               hole_start[pos] = r.region_offset;
               hole_len[pos] = r.region_size;
               hole_count++;
            end else begin
               res.status = ST_FULL;
            end
         end
         owed = {owed, res};
         return res;
      endfunction

      task report_mismatch(string what);
         $display("error: %s", what);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.granted_offset !== want.granted_offset)
            report_mismatch($sformatf("granted_offset %0d, want %0d",
                                      got.granted_offset, want.granted_offset));
         if (got.granted_size !== want.granted_size)
            report_mismatch($sformatf("granted_size %0d, want %0d",
                                      got.granted_size, want.granted_size));
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   region_scoreboard sb;
   int cycle_count;
   bit gapless;          // stretch with no idling on the request side
   logic [LEN_W-1:0] pool_now;
   // regions currently held by the test, returned later by free items
   logic [START_W-1:0] held_off[$];
   logic [LEN_W-1:0] held_len[$];

   free_list_region_allocator_unit #(.FREE_ENTRIES(TABLE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every result strobe against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // Abort on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Present one item from a falling edge; hold start until the block takes it.
   // Return at a falling edge with start still high, so back-to-back items
   // need no second assignment in one step.
   task send_item(input req_type r);
      int gap;
      rsp_type res;
      gap = gapless ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item = r;
      start = 1'b1;
      do @(posedge clock); while (busy);
      res = sb.note_item(r);
      // remember successful grants so that later frees give them back
      if (r.operation == OP_ALLOC && res.status == ST_DONE && r.region_size != 0) begin
         held_off = {held_off, res.granted_offset};
         held_len = {held_len, r.region_size};
      end
      @(negedge clock);
   endtask

   task send_alloc(input logic [LEN_W-1:0] sz);
      req_type r;
      r = '0;
      r.operation = OP_ALLOC;
      r.region_size = sz;
      r.region_offset = START_W'($urandom());
      send_item(r);
   endtask

   task send_free(input logic [START_W-1:0] off, input logic [LEN_W-1:0] sz);
      req_type r;
      r.operation = OP_FREE;
      r.region_size = sz;
      r.region_offset = off;
      send_item(r);
   endtask

   // Give back a randomly chosen held region
   task free_held();
      int k;
      logic [START_W-1:0] off;
      logic [LEN_W-1:0] sz;
      k = $urandom_range(0, held_off.size() - 1);
      off = held_off[k];
      sz = held_len[k];
      held_off.delete(k);
      held_len.delete(k);
      send_free(off, sz);
   endtask

   // Drain outstanding results, then let the block settle before a register write
   task wait_idle();
      start = 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task write_pool(input logic [LEN_W-1:0] pool);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_wr_data = pool;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.reseed(pool);
      pool_now = pool;
      held_off.delete();
      held_len.delete();
   endtask

   // Mostly well-formed alloc/free traffic with random sizes, plus raw noise
   task random_phase(input int count);
      int pick;
      logic [LEN_W-1:0] cap;
      logic [63:0] noise;
      req_type r;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) gapless = ~gapless;
         pick = $urandom_range(0, 99);
         cap = (pool_now >> 3) + LEN_W'(1);
         if (pick < 10) begin
            noise = {$urandom(), $urandom()};
            r = noise[$bits(req_type)-1:0];
            send_item(r);
         end else if (pick < 55 || held_off.size() == 0) begin
            if ($urandom_range(0, 3) == 0)
               send_alloc(LEN_W'($urandom_range(0, 4)));
            else if ($urandom_range(0, 9) == 0)
               send_alloc(cap << $urandom_range(0, 4));
            else
               send_alloc(LEN_W'($urandom_range(1, cap)));
         end else begin
            free_held();
         end
      end
   endtask

   initial begin
      sb = new();
      cycle_count = 0;
      gapless = 1'b0;
      pool_now = POOL_RESET;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: zero-size grant, whole-pool exact match, empty table
      send_alloc('0);
      send_alloc(POOL_RESET);
      send_alloc(26'd5);
      // zero-length entry, then an exact zero-size match on it
      send_free('0, '0);
      send_alloc('0);
      // extreme fields; successor merge that saturates the length
      send_free({START_W{1'b1}}, POOL_MAX);
      send_free(25'd100, 26'd33554331);
      send_alloc(POOL_MAX);
      // a region touching both neighbours joins only the one before it
      send_free(25'd0, 26'd10);
      send_free(25'd20, 26'd5);
      send_free(25'd10, 26'd10);
      send_alloc(26'd3);
      send_alloc(26'd17);
      // carving past the top of the offset space wraps the start
      send_free(25'd33554430, 26'd40);
      send_alloc(26'd8);
      send_alloc(26'd32);
      // duplicate free of a region already free
      send_free(25'd20, 26'd5);
      send_alloc(26'd50);

      // Fill the table: unit grants freed every other one
      write_pool(26'd300);
      for (int n = 0; n < 140; n++) send_alloc(26'd1);
      for (int n = 0; n < 140; n += 2) send_free(n[START_W-1:0], 26'd1);
      send_free(25'd299, 26'd1);
      send_alloc(26'd2);

      write_pool(26'd1);
      random_phase(150);
      write_pool(POOL_MAX);
      random_phase(350);
      write_pool(26'd200);
      random_phase(350);
      write_pool(POOL_RESET);
      random_phase(350);
      write_pool(LEN_W'($urandom_range(1000, 100000)));
      random_phase(300);

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+design
design/flra_pkg.sv
design/flra_ram.sv
design/free_list_region_allocator_unit.sv
test/tb_free_list_region_allocator_unit.sv
